>>> rtl/core/linear_probe_hash_with_rehash_macros.svh
// Assertion macros for the linear probe hash block.
// Used by the top level only; depends on signals clk and rst_n in scope.
`ifndef LINEAR_PROBE_HASH_WITH_REHASH_MACROS_SVH
`define LINEAR_PROBE_HASH_WITH_REHASH_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPH_ASSERT_IMP(lbl, ante, cons, msg)
`define LPH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/lph_pkg.sv
// Package for the linear probe hash block: codes, slot encodings, FSM states.
// No dependencies.
`timescale 1ns / 1ps

package lph_pkg;

  localparam int KEY_W  = 31;
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [31:0] SLOT_EMPTY   = 32'h0000_0000;
  localparam logic [31:0] SLOT_DELETED = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic                big;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MODK,
    S_PRD,
    S_PCHK,
    S_MIG_RD,
    S_MIG_CHK,
    S_MIG_NEXT,
    S_DONE
  } state_t;

endpackage

>>> rtl/core/lph_in_if.sv
// Command channel interface: valid/ready plus cmd and key.
// Depends on lph_pkg for field widths.
`timescale 1ns / 1ps

interface lph_in_if;
  logic                          valid;
  logic                          ready;
  logic [lph_pkg::CMD_W-1:0]     cmd;
  logic [lph_pkg::KEY_W-1:0]     key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

>>> rtl/core/lph_out_if.sv
// Result channel interface: valid/ready plus status, slot and table flag.
// Depends on lph_pkg for field widths.
`timescale 1ns / 1ps

interface lph_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [lph_pkg::SLOT_W-1:0]    slot;
  logic                          in_big_table;

  modport source (output valid, output status, output slot, output in_big_table, input ready);
  modport sink   (input valid, input status, input slot, input in_big_table, output ready);
endinterface

>>> rtl/core/lph_mod.sv
// Shared remainder unit: 31-bit value mod one of two fixed divisors, by
// reciprocal multiplication. Depends on lph_pkg.
`timescale 1ns / 1ps

module lph_mod #(
  parameter int DW      = 5,
  parameter int D_SMALL = 8,
  parameter int D_BIG   = 17
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lph_pkg::KEY_W-1:0] dvd,
  input  logic                      big,
  output logic                      done,
  output logic [DW-1:0]             rem
);

  localparam int KW = lph_pkg::KEY_W;
  localparam int PW = KW + 32;

  // q = (n * m) >> s with m = ceil(2^s / d), s = KW + clog2(d); exact for n < 2^KW
  localparam int SH_S = KW + $clog2(D_SMALL);
  localparam int SH_B = KW + $clog2(D_BIG);
  localparam logic [63:0] MAG_S64 = ((64'd1 << SH_S) + 64'(D_SMALL) - 64'd1) / 64'(D_SMALL);
  localparam logic [63:0] MAG_B64 = ((64'd1 << SH_B) + 64'(D_BIG) - 64'd1) / 64'(D_BIG);
  localparam logic [31:0] MAG_S = MAG_S64[31:0];
  localparam logic [31:0] MAG_B = MAG_B64[31:0];
  localparam logic [DW-1:0] DIV_S = DW'(D_SMALL);
  localparam logic [DW-1:0] DIV_B = DW'(D_BIG);

  logic [KW-1:0] dvd_r;
  logic          big_r;
  logic [PW-1:0] prod_r;
  logic [KW-1:0] qd_r;
  logic [DW-1:0] rem_r;
  logic [2:0]    stg_r;
  logic          done_r;
  logic [31:0]   mag;
  logic [DW-1:0] div_c;
  logic [PW-1:0] prod;
  logic [KW-1:0] quo;
  logic [KW-1:0] qd;
  logic [KW-1:0] diff;

  assign mag   = big_r ? MAG_B : MAG_S;
  assign div_c = big_r ? DIV_B : DIV_S;
  assign prod  = {32'd0, dvd_r} * {31'd0, mag};
  assign quo   = big_r ? KW'(prod_r >> SH_B) : KW'(prod_r >> SH_S);
  assign qd    = quo * KW'(div_c);
  assign diff  = dvd_r - qd_r;

  // step marker: multiply, quotient times divisor, subtract
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r  <= '0;
      done_r <= 1'b0;
    end else begin
      stg_r  <= {stg_r[1:0], start};
      done_r <= stg_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dvd;
      big_r <= big;
    end
    if (stg_r[0]) prod_r <= prod;
    if (stg_r[1]) qd_r <= qd;
    if (stg_r[2]) rem_r <= diff[DW-1:0];
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/lph_ctrl.sv
// Sequencer and table memories for the linear probe hash block.
// Depends on lph_pkg and lph_mod.
`timescale 1ns / 1ps

module lph_ctrl #(
  parameter int SMALL_SIZE  = 8,
  parameter int BIG_MODULUS = 17
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lph_pkg::CMD_W-1:0]  in_cmd,
  input  logic [lph_pkg::KEY_W-1:0]  in_key,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lph_pkg::res_t              res
);

  localparam int MAXD = (SMALL_SIZE > BIG_MODULUS) ? SMALL_SIZE : BIG_MODULUS;
  localparam int IW   = $clog2(MAXD);
  localparam int SW   = $clog2(SMALL_SIZE);
  localparam int BW   = $clog2(BIG_MODULUS);
  localparam int DW   = $clog2(MAXD + 1);

  localparam logic [IW-1:0] SMALL_LAST   = IW'(SMALL_SIZE - 1);
  localparam logic [IW-1:0] BIG_LAST     = IW'(BIG_MODULUS - 1);
  localparam logic [IW-1:0] MAX_LAST     = IW'(MAXD - 1);
  localparam logic [SW-1:0] SMALL_LAST_S = SW'(SMALL_SIZE - 1);

  lph_pkg::state_t state_r, state_nxt;

  logic [IW-1:0]              idx_r, idx_nxt;
  logic [IW-1:0]              cnt_r, cnt_nxt;
  logic [SW-1:0]              mi_r, mi_nxt;
  logic [31:0]                mval_r, mval_nxt;
  logic [lph_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lph_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic                       sel_r, sel_nxt;
  logic                       free_r, free_nxt;
  logic                       mig_r, mig_nxt;
  logic                       big_r, big_nxt;
  lph_pkg::status_t           status_r, status_nxt;
  logic [lph_pkg::SLOT_W-1:0] slot_r, slot_nxt;

  logic                       mod_start;
  logic [lph_pkg::KEY_W-1:0]  mod_dvd;
  logic                       mod_big;
  logic                       mod_done;
  logic [DW-1:0]              mod_rem;

  logic [31:0] small_mem [SMALL_SIZE];
  logic [31:0] big_mem   [BIG_MODULUS];
  logic [31:0] sm_q, bg_q;
  logic [SW-1:0] sm_addr;
  logic [BW-1:0] bg_addr;
  logic          sm_we, bg_we;
  logic [31:0]   wdata;

  logic [31:0]   rdata;
  logic [IW-1:0] size_last;
  logic          free_hit, key_hit, sm_live, cmd_ok;

  lph_mod #(
    .DW      (DW),
    .D_SMALL (SMALL_SIZE),
    .D_BIG   (BIG_MODULUS)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .dvd   (mod_dvd),
    .big   (mod_big),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // tables: one port each, registered read
  assign sm_addr = (state_r == lph_pkg::S_MIG_RD) ? mi_r : idx_r[SW-1:0];
  assign bg_addr = idx_r[BW-1:0];

  always_ff @(posedge clk) begin
    if (sm_we) small_mem[sm_addr] <= wdata;
    sm_q <= small_mem[sm_addr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) big_mem[bg_addr] <= wdata;
    bg_q <= big_mem[bg_addr];
  end

  assign rdata     = sel_r ? bg_q : sm_q;
  assign size_last = sel_r ? BIG_LAST : SMALL_LAST;
  assign free_hit  = (rdata == lph_pkg::SLOT_EMPTY) || (rdata == lph_pkg::SLOT_DELETED);
  assign key_hit   = (rdata == {1'b0, key_r});
  assign sm_live   = (sm_q != lph_pkg::SLOT_EMPTY) && (sm_q != lph_pkg::SLOT_DELETED);
  assign cmd_ok    = (in_cmd == lph_pkg::CMD_INSERT) || (in_cmd == lph_pkg::CMD_DELETE) ||
                     (in_cmd == lph_pkg::CMD_SEARCH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lph_pkg::S_CLEAR;
      idx_r   <= '0;
      mig_r   <= 1'b0;
      big_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mig_r   <= mig_nxt;
      big_r   <= big_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mi_r     <= mi_nxt;
    mval_r   <= mval_nxt;
    key_r    <= key_nxt;
    cmd_r    <= cmd_nxt;
    sel_r    <= sel_nxt;
    free_r   <= free_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    mi_nxt     = mi_r;
    mval_nxt   = mval_r;
    key_nxt    = key_r;
    cmd_nxt    = cmd_r;
    sel_nxt    = sel_r;
    free_nxt   = free_r;
    mig_nxt    = mig_r;
    big_nxt    = big_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    mod_start  = 1'b0;
    mod_dvd    = key_r;
    mod_big    = 1'b1;
    sm_we      = 1'b0;
    bg_we      = 1'b0;
    wdata      = lph_pkg::SLOT_EMPTY;

    unique case (state_r)
      lph_pkg::S_CLEAR: begin
        sm_we = (idx_r <= SMALL_LAST);
        bg_we = (idx_r <= BIG_LAST);
        if (idx_r == MAX_LAST) begin
          idx_nxt   = '0;
          state_nxt = lph_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      lph_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_cmd;
          key_nxt = in_key;
          if ((in_key == '0) || !cmd_ok) begin
            status_nxt = lph_pkg::ST_NOT_FOUND;
            slot_nxt   = '0;
            state_nxt  = lph_pkg::S_DONE;
          end else begin
            sel_nxt   = big_r;
            free_nxt  = (in_cmd == lph_pkg::CMD_INSERT);
            mod_start = 1'b1;
            mod_dvd   = in_key;
            mod_big   = big_r;
            state_nxt = lph_pkg::S_MODK;
          end
        end
      end

      lph_pkg::S_MODK: begin
        if (mod_done) begin
          idx_nxt   = mod_rem[IW-1:0];
          cnt_nxt   = '0;
          state_nxt = lph_pkg::S_PRD;
        end
      end

      lph_pkg::S_PRD: state_nxt = lph_pkg::S_PCHK;

      lph_pkg::S_PCHK: begin
        if (free_r ? free_hit : key_hit) begin
          if (free_r) begin
            wdata = mig_r ? mval_r : {1'b0, key_r};
            sm_we = !sel_r;
            bg_we = sel_r;
          end else if (cmd_r == lph_pkg::CMD_DELETE) begin
            wdata = lph_pkg::SLOT_DELETED;
            sm_we = !sel_r;
            bg_we = sel_r;
          end
          if (mig_r) begin
            state_nxt = lph_pkg::S_MIG_NEXT;
          end else begin
            status_nxt = lph_pkg::ST_OK;
            slot_nxt   = lph_pkg::SLOT_W'(idx_r);
            state_nxt  = lph_pkg::S_DONE;
          end
        end else if (cnt_r == size_last) begin
          if (mig_r) begin
            // no room in the big table: key dropped
            state_nxt = lph_pkg::S_MIG_NEXT;
          end else if (free_r && !sel_r) begin
            mig_nxt   = 1'b1;
            mi_nxt    = '0;
            state_nxt = lph_pkg::S_MIG_RD;
          end else begin
            status_nxt = free_r ? lph_pkg::ST_FULL : lph_pkg::ST_NOT_FOUND;
            slot_nxt   = '0;
            state_nxt  = lph_pkg::S_DONE;
          end
        end else begin
          idx_nxt   = (idx_r == size_last) ? '0 : idx_r + 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = lph_pkg::S_PRD;
        end
      end

      lph_pkg::S_MIG_RD: state_nxt = lph_pkg::S_MIG_CHK;

      lph_pkg::S_MIG_CHK: begin
        if (sm_live) begin
          mval_nxt  = sm_q;
          sel_nxt   = 1'b1;
          mod_start = 1'b1;
          mod_dvd   = sm_q[lph_pkg::KEY_W-1:0];
          state_nxt = lph_pkg::S_MODK;
        end else begin
          state_nxt = lph_pkg::S_MIG_NEXT;
        end
      end

      lph_pkg::S_MIG_NEXT: begin
        if (mi_r == SMALL_LAST_S) begin
          // migration over: insert the pending key into the big table
          mig_nxt   = 1'b0;
          big_nxt   = 1'b1;
          sel_nxt   = 1'b1;
          mod_start = 1'b1;
          state_nxt = lph_pkg::S_MODK;
        end else begin
          mi_nxt    = mi_r + 1'b1;
          state_nxt = lph_pkg::S_MIG_RD;
        end
      end

      lph_pkg::S_DONE: begin
        if (res_ready) state_nxt = lph_pkg::S_IDLE;
      end

      default: state_nxt = lph_pkg::S_IDLE;
    endcase
  end

  assign in_ready   = (state_r == lph_pkg::S_IDLE);
  assign res_valid  = (state_r == lph_pkg::S_DONE);
  assign res.status = status_r;
  assign res.slot   = slot_r;
  assign res.big    = big_r;

endmodule

>>> rtl/core/linear_probe_hash_with_rehash.sv
// Linear probe hash table with one-time rehash. An item runs through the key
// remainder, a read and a check per probed slot, and the hand-over; key zero
// goes straight to hand-over. Migration reads and checks each small slot and
// rehashes and probes each live key. One item at a time: the next item is
// taken in the cycle after the result leaves the core. Reset (sync, active
// low) runs a clearing pass over both tables before the first item is taken.
`timescale 1ns / 1ps
`include "linear_probe_hash_with_rehash_macros.svh"

module linear_probe_hash_with_rehash #(
  parameter int SMALL_SIZE  = 8,
  parameter int BIG_MODULUS = 17
) (
  input  logic      clk,
  input  logic      rst_n,
  lph_in_if.sink    in_ch,
  lph_out_if.source out_ch
);

  // sequencer side of the result path
  logic          res_valid;
  logic          res_ready;
  lph_pkg::res_t res;

  // output register parts the result channel from the sequencer
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [lph_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_big_r;

  lph_ctrl #(
    .SMALL_SIZE  (SMALL_SIZE),
    .BIG_MODULUS (BIG_MODULUS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_key    (in_ch.key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // a finished item moves on once the output register is free or draining
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_slot_r   <= res.slot;
      out_big_r    <= res.big;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.in_big_table = out_big_r;

  // checks
  `LPH_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `LPH_ASSERT_NXT(a_big_sticky, res.big, res.big, "big table flag dropped")
  `LPH_ASSERT_IMP(a_slot_zero, res_valid && (res.status != lph_pkg::ST_OK), res.slot == '0, "slot not zero on failure")
  `LPH_ASSERT_IMP(a_full_big, res_valid && (res.status == lph_pkg::ST_FULL), res.big, "full without big table")

endmodule
